// File: sv/box_average_frame_downscaler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box-average downscaler
// Shared concurrent check forms, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_FRAME_DOWNSCALER_MACROS_SVH
`define BOX_AVERAGE_FRAME_DOWNSCALER_MACROS_SVH

// condition that must hold at every edge out of reset
`define BAFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define BAFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bafd_pkg.sv
// ----------------------------------------------------------------------------
// bafd_pkg
// Constants, types and size clamps for the box-average frame downscaler.
// ----------------------------------------------------------------------------
package bafd_pkg;

    localparam int SRC_WIDTH   = 320;
    localparam int SRC_HEIGHT  = 200;
    localparam int MAX_COLUMNS = 320;

    // configured size limits
    localparam int MIN_COLS = 20;
    localparam int TOP_COLS = 320;
    localparam int MIN_ROWS = 10;
    localparam int TOP_ROWS = 100;
    localparam int COL_CAP0 = (TOP_COLS < MAX_COLUMNS) ? TOP_COLS : MAX_COLUMNS;
    localparam int COL_CAP  = (COL_CAP0 < SRC_WIDTH) ? COL_CAP0 : SRC_WIDTH;
    localparam int ROW_CAP0 = SRC_HEIGHT / 2;
    localparam int ROW_CAP  = (TOP_ROWS < ROW_CAP0) ? TOP_ROWS : ROW_CAP0;

    // register reset values
    localparam logic [8:0] COLS_RST = 9'd80;
    localparam logic [6:0] ROWS_RST = 7'd24;

    // register indexes
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // position products: (x+2)*C, (i+1)*W and (y+2)*V, (j+1)*H
    localparam int XP_W = 17;
    localparam int YP_W = 16;

    // accumulator entry: three 16-bit sums and an 8-bit pixel count
    localparam int SUM_W = 16;
    localparam int CNT_W = 8;
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] r;
    } t_acc;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    function automatic logic [8:0] sat_cols(input logic [8:0] c);
        logic [8:0] v;
        v = c;
        if (v < 9'(MIN_COLS)) v = 9'(MIN_COLS);
        if (v > 9'(COL_CAP))  v = 9'(COL_CAP);
        return v;
    endfunction

    // returns virtual rows (twice the text rows)
    function automatic logic [7:0] sat_vrows(input logic [6:0] r);
        logic [6:0] v;
        v = r;
        if (v < 7'(MIN_ROWS)) v = 7'(MIN_ROWS);
        if (v > 7'(ROW_CAP))  v = 7'(ROW_CAP);
        return {v, 1'b0};
    endfunction

endpackage

// File: sv/box_average_frame_downscaler.sv
// ----------------------------------------------------------------------------
// box_average_frame_downscaler
// Area-average downscale of a raster RGB frame into a grid of cells.
// ----------------------------------------------------------------------------
// Channel | Beat fields (lowest bit first)                    | Marker
// s_axis  | tdata: red_in, green_in, blue_in                 | tuser: frame_start
// m_axis  | tdata: cell_row, cell_col, red/green/blue_avg    | tlast: frame_done
// cfg     | addr 0: output_columns, addr 1: output_rows      | write only
//
// A pixel passes through accumulator read, update and write-back; one that
// closes a cell then runs the 8-step shared mean divider and the hand-off to
// the output register. The next pixel is taken while a cell waits there.
// Reset is synchronous, active low; sizes latch at each frame start.
// A stalled output only holds the block once a second cell is ready.
// ----------------------------------------------------------------------------
module box_average_frame_downscaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_data,
    // pixel stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red_in, green_in, blue_in
    input  logic        i_s_tuser,   // frame_start
    // cell stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // cell_row, cell_col, red/green/blue_avg, zero pad
    output logic        o_m_tlast    // frame_done
);
    import bafd_pkg::*;

    t_state      r_state;
    logic [8:0]  r_cfg_cols;
    logic [6:0]  r_cfg_rows;
    logic [8:0]  r_cols;
    logic [7:0]  r_vrows;
    logic [8:0]  r_x;
    logic [7:0]  r_y;
    logic [8:0]  r_col;
    logic [7:0]  r_band;
    logic [XP_W-1:0] r_xc, r_xw;
    logic [YP_W-1:0] r_yv, r_jh;
    logic        r_first;
    logic [7:0]  r_pr, r_pg, r_pb;
    t_acc        r_rd;
    t_acc        mem [MAX_COLUMNS];
    // divider
    logic [SUM_W-1:0] r_rem [3];
    logic [7:0]  r_q [3];
    logic [CNT_W-1:0] r_dn;
    logic [2:0]  r_k;
    logic [7:0]  r_c_row;
    logic [8:0]  r_c_col;
    logic        r_c_last;
    // output register
    logic        r_o_valid;
    logic [47:0] r_o_data;
    logic        r_o_last;

    logic [8:0]  w_fs_cols;
    logic [7:0]  w_fs_vrows;
    t_acc        w_wr;
    logic        w_last_col, w_last_row, w_emit;
    logic [SUM_W-1:0] w_dsh;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

    assign w_fs_cols  = sat_cols(r_cfg_cols);
    assign w_fs_vrows = sat_vrows(r_cfg_rows);

    // cell edges by cross-multiplied compares
    assign w_last_col = (r_xc > r_xw);
    assign w_last_row = (r_yv > r_jh);
    assign w_emit     = w_last_col && w_last_row;

    // accumulator update: first row of a band overwrites
    always_comb begin
        if (r_first) begin
            w_wr.r = SUM_W'(r_pr);
            w_wr.g = SUM_W'(r_pg);
            w_wr.b = SUM_W'(r_pb);
            w_wr.n = CNT_W'(1);
        end else begin
            w_wr.r = r_rd.r + SUM_W'(r_pr);
            w_wr.g = r_rd.g + SUM_W'(r_pg);
            w_wr.b = r_rd.b + SUM_W'(r_pb);
            w_wr.n = r_rd.n + CNT_W'(1);
        end
    end

    assign w_dsh = SUM_W'(r_dn) << r_k;

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) r_rd <= mem[r_col];
        if (r_state == S_UPD) mem[r_col] <= w_wr;
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_cols <= COLS_RST;
            r_cfg_rows <= ROWS_RST;
            r_cols     <= sat_cols(COLS_RST);
            r_vrows    <= sat_vrows(ROWS_RST);
            r_x        <= '0;
            r_y        <= '0;
            r_col      <= '0;
            r_band     <= '0;
            r_xc       <= XP_W'({sat_cols(COLS_RST), 1'b0});
            r_xw       <= XP_W'(SRC_WIDTH);
            r_yv       <= YP_W'({sat_vrows(ROWS_RST), 1'b0});
            r_jh       <= YP_W'(SRC_HEIGHT);
            r_first    <= 1'b1;
            r_o_valid  <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_COLS: r_cfg_cols <= i_cfg_data;
                    CFG_ROWS: r_cfg_rows <= i_cfg_data[6:0];
                    default:  ;
                endcase
            end
            // S_PUT reloads the output register itself
            if (r_o_valid && i_m_tready && r_state != S_PUT) r_o_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_pr <= i_s_tdata[7:0];
                        r_pg <= i_s_tdata[15:8];
                        r_pb <= i_s_tdata[23:16];
                        if (i_s_tuser) begin
                            r_cols  <= w_fs_cols;
                            r_vrows <= w_fs_vrows;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_col   <= '0;
                            r_band  <= '0;
                            r_xc    <= XP_W'({w_fs_cols, 1'b0});
                            r_xw    <= XP_W'(SRC_WIDTH);
                            r_yv    <= YP_W'({w_fs_vrows, 1'b0});
                            r_jh    <= YP_W'(SRC_HEIGHT);
                            r_first <= 1'b1;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    // start divider for a finished cell
                    r_rem[0] <= w_wr.r;
                    r_rem[1] <= w_wr.g;
                    r_rem[2] <= w_wr.b;
                    r_dn     <= w_wr.n;
                    r_k      <= 3'd7;
                    r_c_row  <= r_band;
                    r_c_col  <= r_col;
                    r_c_last <= (r_col + 9'd1 == r_cols) && (r_band + 8'd1 == r_vrows);
                    r_state  <= w_emit ? S_DIV : S_IDLE;
                    // advance source position
                    if (r_x == 9'(SRC_WIDTH - 1)) begin
                        if (r_y == 8'(SRC_HEIGHT - 1)) begin
                            r_cols  <= w_fs_cols;
                            r_vrows <= w_fs_vrows;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_col   <= '0;
                            r_band  <= '0;
                            r_xc    <= XP_W'({w_fs_cols, 1'b0});
                            r_xw    <= XP_W'(SRC_WIDTH);
                            r_yv    <= YP_W'({w_fs_vrows, 1'b0});
                            r_jh    <= YP_W'(SRC_HEIGHT);
                            r_first <= 1'b1;
                        end else begin
                            r_x   <= '0;
                            r_col <= '0;
                            r_xc  <= XP_W'({r_cols, 1'b0});
                            r_xw  <= XP_W'(SRC_WIDTH);
                            r_y   <= r_y + 8'd1;
                            r_yv  <= r_yv + YP_W'(r_vrows);
                            if (w_last_row) begin
                                r_band  <= r_band + 8'd1;
                                r_jh    <= r_jh + YP_W'(SRC_HEIGHT);
                                r_first <= 1'b1;
                            end else begin
                                r_first <= 1'b0;
                            end
                        end
                    end else begin
                        r_x  <= r_x + 9'd1;
                        r_xc <= r_xc + XP_W'(r_cols);
                        if (w_last_col) begin
                            r_col <= r_col + 9'd1;
                            r_xw  <= r_xw + XP_W'(SRC_WIDTH);
                        end
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle for each channel
                    for (int c = 0; c < 3; c++) begin
                        if (r_rem[c] >= w_dsh) begin
                            r_rem[c]    <= r_rem[c] - w_dsh;
                            r_q[c][r_k] <= 1'b1;
                        end else begin
                            r_q[c][r_k] <= 1'b0;
                        end
                    end
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0) r_state <= S_PUT;
                end
                S_PUT: begin
                    if (!r_o_valid || i_m_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {7'd0, r_q[2], r_q[1], r_q[0], r_c_col, r_c_row};
                        r_o_last  <= r_c_last;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
`include "box_average_frame_downscaler_macros.svh"
    `BAFD_ASSERT_ALWAYS(a_col_in_range, (r_col < r_cols) && (r_band < r_vrows), "position outside grid")
    `BAFD_ASSERT_NEXT(a_accept_reads, i_s_tvalid && o_s_tready, r_state == S_RD, "accepted pixel not read")
    `BAFD_ASSERT_NEXT(a_div_ends, r_state == S_DIV && r_k == 3'd0, r_state == S_PUT, "divider overran")

endmodule

// File: test/box_average_frame_downscaler_tb.sv
// ----------------------------------------------------------------------------
// box_average_frame_downscaler_tb
// Streams pixels into the downscaler and checks every emitted cell against a
// behavioural predictor of the box average. It covers saturated and latched
// sizes, early frame starts and stalls on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_average_frame_downscaler_tb;
    import bafd_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;
    localparam int MAX_PRINTS = 20;

    typedef struct packed {
        logic [7:0] row;
        logic [8:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_cell;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [8:0]  i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // red_in, green_in, blue_in
    logic        i_s_tuser;   // frame_start
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // cell_row, cell_col, red/green/blue_avg, zero pad
    logic        o_m_tlast;   // frame_done

    box_average_frame_downscaler uut (.*);

    // stall and idle shaping
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int          recv_hold_cycles;

    // predictor state
    int unsigned sum_red [MAX_COLUMNS];
    int unsigned sum_grn [MAX_COLUMNS];
    int unsigned sum_blu [MAX_COLUMNS];
    int unsigned pix_cnt [MAX_COLUMNS];
    int unsigned pos_x, pos_y, col_idx, band_idx, edge_x, edge_y;
    int unsigned reg_cols, reg_rows, live_cols, live_vrows;

    t_cell       pending_cells[$];
    int unsigned errors, prints, pixels_sent, cells_seen, frames_done;
    int unsigned quiet_cycles;

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned col_edge(input int unsigned i);
        return (i * SRC_WIDTH) / live_cols;
    endfunction

    function automatic int unsigned row_edge(input int unsigned j);
        return (j * SRC_HEIGHT) / live_vrows;
    endfunction

    // sizes are clamped and latched at each frame start
    function automatic void latch_frame();
        int unsigned c, r;
        c = reg_cols;
        r = reg_rows;
        if (c < MIN_COLS) c = MIN_COLS;
        if (c > COL_CAP)  c = COL_CAP;
        if (r < MIN_ROWS) r = MIN_ROWS;
        if (r > ROW_CAP)  r = ROW_CAP;
        live_cols  = c;
        live_vrows = 2 * r;
        pos_x = 0;
        pos_y = 0;
        col_idx = 0;
        band_idx = 0;
        edge_x = col_edge(1);
        edge_y = row_edge(1);
    endfunction

    function automatic void average_pixel(input logic fs, input logic [23:0] px);
        int unsigned c;
        t_cell exp_cell;
        if (fs) latch_frame();
        c = (col_idx >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_idx;
        // first row of a band restarts the column sums
        if (pos_y == row_edge(band_idx)) begin
            sum_red[c] = px[7:0];
            sum_grn[c] = px[15:8];
            sum_blu[c] = px[23:16];
            pix_cnt[c] = 1;
        end else begin
            sum_red[c] += px[7:0];
            sum_grn[c] += px[15:8];
            sum_blu[c] += px[23:16];
            pix_cnt[c] += 1;
        end
        if (pos_x + 1 == edge_x && pos_y + 1 == edge_y) begin
            exp_cell.row   = band_idx[7:0];
            exp_cell.col   = col_idx[8:0];
            exp_cell.red   = 8'(sum_red[c] / pix_cnt[c]);
            exp_cell.green = 8'(sum_grn[c] / pix_cnt[c]);
            exp_cell.blue  = 8'(sum_blu[c] / pix_cnt[c]);
            exp_cell.last  = (col_idx + 1 == live_cols) && (band_idx + 1 == live_vrows);
            pending_cells.push_back(exp_cell);
        end
        // advance raster position
        pos_x++;
        if (pos_x == edge_x && pos_x < SRC_WIDTH) begin
            col_idx++;
            edge_x = col_edge(col_idx + 1);
        end
        if (pos_x >= SRC_WIDTH) begin
            pos_x = 0;
            col_idx = 0;
            edge_x = col_edge(1);
            pos_y++;
            if (pos_y >= SRC_HEIGHT) begin
                latch_frame();
            end else if (pos_y == edge_y) begin
                band_idx++;
                edge_y = row_edge(band_idx + 1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Pixel sender: one beat, with random idle gaps before it
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic fs, input logic [23:0] px);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= fs;
        i_s_tdata  <= px;
        forever begin
            @(negedge i_clk);
            if (o_s_tready) begin
                average_pixel(fs, px);
                pixels_sent++;
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input logic fs);
        send_pixel(fs, 24'($urandom));
    endtask

    // wait for every cell, then for the divider to go quiet
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // both registers, only while the block is idle
    task automatic write_sizes(input logic [8:0] cols, input logic [8:0] rows);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_addr <= CFG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reg_cols = cols & 9'h1FF;
        reg_rows = rows & 9'h07F;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cell checker and watchdog, sampled away from the driving edge
    always @(negedge i_clk) begin
        t_cell got, want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_s_tvalid && o_s_tready) quiet_cycles = 0;
            if (o_m_tvalid && i_m_tready) begin
                quiet_cycles = 0;
                cells_seen++;
                got.row   = o_m_tdata[7:0];
                got.col   = o_m_tdata[16:8];
                got.red   = o_m_tdata[24:17];
                got.green = o_m_tdata[32:25];
                got.blue  = o_m_tdata[40:33];
                got.last  = o_m_tlast;
                if (got.last) frames_done++;
                if (pending_cells.size() == 0) begin
                    errors++;
                    if (prints++ < MAX_PRINTS)
                        $display("%0t: unexpected cell, exp none, got %h", $time, got);
                end else begin
                    want = pending_cells.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (prints++ < MAX_PRINTS)
                            $display("%0t: cell mismatch exp row %0d col %0d rgb %0d %0d %0d last %0b, got row %0d col %0d rgb %0d %0d %0d last %0b",
                                $time, want.row, want.col, want.red, want.green, want.blue,
                                want.last, got.row, got.col, got.red, got.green, got.blue,
                                got.last);
                    end
                end
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // reset sizes: first row of an 80x48 grid emits nothing yet
        send_pixel(1'b1, 24'h000000);
        repeat (3) send_random(1'b0);
        // saturate high: one-pixel cells, every pixel closes a cell
        write_sizes(9'h1FF, 9'h07F);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hAA55AA);
        send_pixel(1'b0, 24'h55AA55);
        send_pixel(1'b0, 24'hFF00FF);
        // early frame start drops the partial frame
        send_pixel(1'b1, 24'h00FF00);
        send_pixel(1'b0, 24'h123456);
        // just past the caps
        write_sizes(9'd321, 9'd101);
        send_pixel(1'b1, 24'hFEDCBA);
        repeat (4) send_random(1'b0);
        // sizes written mid-frame only apply from the next frame start
        write_sizes(9'd20, 9'd10);
        repeat (3) send_random(1'b0);
        send_random(1'b1);
        repeat (3) send_random(1'b0);
    endtask

    task automatic test_random(input int unsigned n_items);
        int unsigned done, seg;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(9) < 7)
                write_sizes(9'($urandom_range(160, 320)), 9'($urandom_range(80, 100)));
            else
                write_sizes(9'($urandom_range(0, 511)), 9'($urandom_range(0, 127)));
            seg = $urandom_range(20, 80);
            // mostly a clean frame start; sometimes carry on the old frame
            send_random($urandom_range(4) != 0);
            repeat (seg - 1) send_random($urandom_range(29) == 0);
            done += seg;
        end
    endtask

    // output held off long enough that the block must stall its input
    task automatic test_backpressure();
        write_sizes(9'd320, 9'd100);
        recv_hold_cycles = 3000;
        send_random(1'b1);
        repeat (150) send_random(1'b0);
        // sender waits for every cell before going on
        drain();
        repeat (50) send_random(1'b0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_COLS;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        send_gap_pct = 16;
        recv_stall_pct = 71;
        recv_hold_cycles = 0;
        errors = 0;
        prints = 0;
        pixels_sent = 0;
        cells_seen = 0;
        frames_done = 0;
        quiet_cycles = 0;
        reg_cols = COLS_RST;
        reg_rows = ROWS_RST;
        latch_frame();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(125);
        test_backpressure();
        send_gap_pct = 71;
        recv_stall_pct = 16;
        test_random(125);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(125);
        drain();

        $display("Sent %0d pixels, checked %0d cells, %0d full frames closed.",
            pixels_sent, cells_seen, frames_done);
        $display("Covered size clamps, latched sizes, early frame starts, stalls.");
        if (errors == 0 && pending_cells.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/bafd_pkg.sv
sv/box_average_frame_downscaler.sv
test/box_average_frame_downscaler_tb.sv
